### hw/rtl/eeg_packet_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef EEG_PACKET_DEFRAMER_MACROS_SVH
`define EEG_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define EPD_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication, disabled during reset
`define EPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

### hw/rtl/epd_pkg.sv
// Shared types and constants of the packet deframer.
// No dependencies.
package epd_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int BANDS = 8;
	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 2;

	localparam logic [7:0] SYNC_BYTE = 8'hAA;
	localparam logic [7:0] CODE_QUALITY = 8'd2;
	localparam logic [7:0] CODE_ATTENTION = 8'd4;
	localparam logic [7:0] CODE_MEDITATION = 8'd5;
	localparam logic [7:0] CODE_POWER = 8'd131;
	localparam logic [7:0] QUALITY_RST = 8'd200;
	// length byte plus three bytes per band
	localparam logic [8:0] POWER_NEED = 9'(1 + 3 * BANDS);

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_CKSUM_BAD = 2'd2,
		ST_PARSE_BAD = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_TOO_LONG = 2'd1,
		CMD_CKSUM_BAD = 2'd2,
		CMD_PARSE = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] addr;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic [7:0] quality;
		logic [7:0] attention_level;
		logic [7:0] meditation_level;
		logic power_valid;
		logic [2:0] band_index;
		logic [23:0] band_value;
		logic last;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CODE_RD,
		B_CODE_EV,
		B_VAL,
		B_BAND_RD,
		B_BAND_EV,
		B_EMIT
	} back_state_t;

endpackage

### hw/rtl/epd_fifo.sv
// Small synchronous FIFO used for the command and result queues.
// Depends on the deframer macros header.
`include "eeg_packet_deframer_macros.svh"

module epd_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [W-1:0] wr_data,
	output logic full,
	input logic rd_en,
	output logic [W-1:0] rd_data,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`EPD_ASSERT(a_fifo_cnt, 1'b1, cnt_q <= (AW+1)'(DEPTH))
	`EPD_ASSERT_NEXT(a_fifo_fill, do_wr && !do_rd, !empty)

endmodule

### hw/rtl/epd_front.sv
// Byte framer: sync detection, length check, checksum, payload commands.
// Depends on epd_pkg and the deframer macros header.
`include "eeg_packet_deframer_macros.svh"

module epd_front
	import epd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] rx_byte,
	output logic cmd_push,
	output cmd_t cmd
);
	logic [7:0] prev_q, pos_q, len_q, sum_q;
	logic in_frame_q;
	logic [7:0] pos_n, len_n, sum_n;
	logic fr_n;

	always_comb begin
		fr_n = in_frame_q;
		pos_n = pos_q;
		len_n = len_q;
		sum_n = sum_q;
		cmd_push = 1'b0;
		cmd = '{kind: CMD_WRITE, addr: pos_q - 8'd1, data: rx_byte};
		if (in_frame_q) begin
			if (pos_q == 8'd0) begin
				len_n = rx_byte;
				if (rx_byte > 8'(MAX_LEN)) begin
					fr_n = 1'b0;
					cmd_push = 1'b1;
					cmd.kind = CMD_TOO_LONG;
				end
			end else if (pos_q <= len_q) begin
				cmd_push = 1'b1;
				sum_n = sum_q + rx_byte;
			end else begin
				fr_n = 1'b0;
				cmd_push = 1'b1;
				cmd.data = len_q;
				cmd.kind = (rx_byte != ~sum_q) ? CMD_CKSUM_BAD : CMD_PARSE;
			end
			pos_n = pos_q + 8'd1;
		end
		if (rx_byte == SYNC_BYTE && prev_q == SYNC_BYTE && !fr_n) begin
			fr_n = 1'b1;
			pos_n = '0;
			len_n = '0;
			sum_n = '0;
		end
		cmd_push = cmd_push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			in_frame_q <= 1'b0;
			pos_q <= '0;
			len_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			prev_q <= rx_byte;
			in_frame_q <= fr_n;
			pos_q <= pos_n;
			len_q <= len_n;
			sum_q <= sum_n;
		end
	end

	`EPD_ASSERT(a_len_bound, in_frame_q && pos_q != 8'd0, len_q <= 8'(MAX_LEN))

endmodule

### hw/rtl/epd_back.sv
// Payload store and row parser; emits results into the result queue.
// Depends on epd_pkg and the deframer macros header.
`include "eeg_packet_deframer_macros.svh"

module epd_back
	import epd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic cmd_empty,
	output logic cmd_pop,
	output logic res_push,
	output res_t res,
	input logic res_full
);
	localparam int AW = $clog2(MAX_LEN);

	back_state_t state_q, state_n;
	logic [7:0] mem_q [MAX_LEN];
	logic [7:0] rd_data_q;
	logic [AW-1:0] raddr;
	logic mem_we;

	logic [8:0] i_q, ptr_q;
	logic [7:0] len_q, code_q;
	status_t status_q;
	logic [2:0] eidx_q, bj_q;
	logic [1:0] bk_q;
	logic [15:0] acc_q;
	logic [7:0] quality_q, attention_q, meditation_q;
	logic power_q;
	logic [23:0] band_q [BANDS];
	logic multi, is_row, row_short, pwr_short;

	assign multi = (status_q == ST_OK) && power_q;
	assign is_row = (rd_data_q == CODE_QUALITY) || (rd_data_q == CODE_ATTENTION)
		|| (rd_data_q == CODE_MEDITATION);
	assign row_short = (i_q + 9'd1) >= {1'b0, len_q};
	assign pwr_short = (i_q + POWER_NEED) >= {1'b0, len_q};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[cmd.addr[AW-1:0]] <= cmd.data;
		rd_data_q <= mem_q[raddr];
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			B_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						CMD_WRITE: state_n = B_IDLE;
						CMD_PARSE: state_n = B_CODE_RD;
						default: state_n = B_EMIT;
					endcase
				end
			end
			B_CODE_RD: state_n = (i_q >= {1'b0, len_q}) ? B_EMIT : B_CODE_EV;
			B_CODE_EV: begin
				if (is_row)
					state_n = row_short ? B_EMIT : B_VAL;
				else if (rd_data_q == CODE_POWER)
					state_n = pwr_short ? B_EMIT : B_BAND_RD;
				else
					state_n = B_EMIT;
			end
			B_VAL: state_n = B_CODE_RD;
			B_BAND_RD: state_n = B_BAND_EV;
			B_BAND_EV: begin
				if (bk_q == 2'd2 && bj_q == 3'(BANDS - 1))
					state_n = B_CODE_RD;
				else
					state_n = B_BAND_RD;
			end
			B_EMIT: begin
				if (!res_full && (!multi || eidx_q == 3'(BANDS - 1)))
					state_n = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		mem_we = 1'b0;
		res_push = 1'b0;
		raddr = i_q[AW-1:0];
		case (state_q)
			B_IDLE: begin
				cmd_pop = !cmd_empty;
				mem_we = !cmd_empty && cmd.kind == CMD_WRITE;
			end
			B_CODE_EV: raddr = AW'(i_q + 9'd1);
			B_BAND_RD: raddr = ptr_q[AW-1:0];
			B_EMIT: res_push = !res_full;
			default: raddr = i_q[AW-1:0];
		endcase
		res.status = status_q;
		res.quality = quality_q;
		res.attention_level = attention_q;
		res.meditation_level = meditation_q;
		res.power_valid = power_q;
		res.band_index = eidx_q;
		res.band_value = multi ? band_q[eidx_q] : '0;
		res.last = !multi || eidx_q == 3'(BANDS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			i_q <= '0;
			ptr_q <= '0;
			len_q <= '0;
			code_q <= '0;
			status_q <= ST_OK;
			eidx_q <= '0;
			bj_q <= '0;
			bk_q <= '0;
			acc_q <= '0;
			quality_q <= QUALITY_RST;
			attention_q <= '0;
			meditation_q <= '0;
			power_q <= 1'b0;
			for (int k = 0; k < BANDS; k++)
				band_q[k] <= '0;
		end else begin
			state_q <= state_n;
			case (state_q)
				B_IDLE: begin
					eidx_q <= '0;
					if (!cmd_empty) begin
						case (cmd.kind)
							CMD_TOO_LONG: status_q <= ST_TOO_LONG;
							CMD_CKSUM_BAD: status_q <= ST_CKSUM_BAD;
							CMD_PARSE: begin
								status_q <= ST_OK;
								power_q <= 1'b0;
								i_q <= '0;
								len_q <= cmd.data;
								for (int k = 0; k < BANDS; k++)
									band_q[k] <= '0;
							end
							default: status_q <= status_q;
						endcase
					end
				end
				B_CODE_EV: begin
					code_q <= rd_data_q;
					ptr_q <= i_q + 9'd2;
					bj_q <= '0;
					bk_q <= '0;
					if (is_row ? row_short : (rd_data_q != CODE_POWER || pwr_short))
						status_q <= ST_PARSE_BAD;
				end
				B_VAL: begin
					if (code_q == CODE_QUALITY)
						quality_q <= rd_data_q;
					else if (code_q == CODE_ATTENTION)
						attention_q <= rd_data_q;
					else
						meditation_q <= rd_data_q;
					i_q <= i_q + 9'd2;
				end
				B_BAND_EV: begin
					ptr_q <= ptr_q + 9'd1;
					if (bk_q == 2'd2) begin
						band_q[bj_q] <= {acc_q, rd_data_q};
						bk_q <= '0;
						bj_q <= bj_q + 3'd1;
						if (bj_q == 3'(BANDS - 1)) begin
							power_q <= 1'b1;
							i_q <= i_q + POWER_NEED + 9'd1;
						end
					end else begin
						acc_q <= {acc_q[7:0], rd_data_q};
						bk_q <= bk_q + 2'd1;
					end
				end
				B_EMIT: begin
					if (!res_full)
						eidx_q <= eidx_q + 3'd1;
				end
				default: eidx_q <= eidx_q;
			endcase
		end
	end

	`EPD_ASSERT(a_bk_range, state_q == B_BAND_EV, bk_q != 2'd3)
	`EPD_ASSERT(a_single_idx, state_q == B_EMIT && !multi, eidx_q == 3'd0)

endmodule

### hw/rtl/eeg_packet_deframer.sv
// Packet deframer for sync / length / checksum byte streams with code-value rows.
// Input: push/full, one received byte per transfer on rx_byte.
// Output: empty/pop, one result per transfer; the oldest result is shown while
// empty is low. A packet gives one result, or one per band when it parsed
// without error and carried band powers (last marks the final one).
// A front framer takes one byte per cycle while full is low and issues
// commands into a 4-entry queue; full rises only when that queue is full. A
// back parser, while idle, retires one command per cycle for payload bytes;
// at the end of a good packet it walks the stored payload through its memory,
// then emits results one per cycle into a 2-entry result queue while that
// queue is not full.
// When the receiver stalls, the result queue and then the command queue fill,
// and full holds off new bytes; nothing is dropped.
// Reset clears framing state, queues, stored values (quality to 200) and bands;
// the payload store holds no reset value and is only read after being written.
// Depends on epd_pkg, epd_fifo, epd_front, epd_back.
module eeg_packet_deframer
	import epd_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] rx_byte,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic [7:0] quality,
	output logic [7:0] attention_level,
	output logic [7:0] meditation_level,
	output logic power_valid,
	output logic [2:0] band_index,
	output logic [23:0] band_value,
	output logic last
);
	logic cmd_push, cmd_pop, cmd_empty, res_push, res_full;
	cmd_t cmd_in, cmd_out;
	res_t res_in, res_out;

	epd_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk(clk), .arst_n(arst_n),
		.accept(push && !full), .rx_byte(rx_byte),
		.cmd_push(cmd_push), .cmd(cmd_in)
	);

	epd_fifo #(.W($bits(cmd_t)), .DEPTH(CMDQ_DEPTH)) u_cmdq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(cmd_push), .wr_data(cmd_in), .full(full),
		.rd_en(cmd_pop), .rd_data(cmd_out), .empty(cmd_empty)
	);

	epd_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd_out), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
		.res_push(res_push), .res(res_in), .res_full(res_full)
	);

	epd_fifo #(.W($bits(res_t)), .DEPTH(RESQ_DEPTH)) u_resq (
		.clk(clk), .arst_n(arst_n),
		.wr_en(res_push), .wr_data(res_in), .full(res_full),
		.rd_en(pop), .rd_data(res_out), .empty(empty)
	);

	assign status = res_out.status;
	assign quality = res_out.quality;
	assign attention_level = res_out.attention_level;
	assign meditation_level = res_out.meditation_level;
	assign power_valid = res_out.power_valid;
	assign band_index = res_out.band_index;
	assign band_value = res_out.band_value;
	assign last = res_out.last;

endmodule
